### src/pdq_pkg.sv
`default_nettype none
// ============================================================================
// pdq_pkg: shared types and codes for the positional deque
// Command and status codes, the job and result records, default capacity.
// ============================================================================
package pdq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_OOB   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
    } t_job;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] removed;
    } t_res;

endpackage
`default_nettype wire

### src/positional_deque.sv
`default_nettype none
// ============================================================================
// positional_deque: bounded double-ended queue with positional insert/delete
// Signed 32-bit entries held in one RAM as a circular buffer.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall) carries one command item: command,
//   value, position. Output channel (o_valid / i_stall) returns one result
//   item per command: status, removed value, count after the command.
//   One command is in flight at a time; o_stall is high while it is worked.
//   From accept, a command passes the execute state, then the shift state
//   unless it is an error or an unused code, then the done state, from
//   which its result is loaded into the output register (o_valid).
//   The entry move is limited by the single RAM read port: one entry per
//   cycle is read and written back one place up (insert) or down (delete).
//   The next command is accepted in the cycle after the result leaves the
//   sequencer; until then the next item waits on the input.
//   A stalled receiver holds its result in the output register; the next
//   result then waits in the sequencer, which keeps o_stall high.
//   Reset (synchronous, active low) empties the store; no RAM clearing pass.
// ============================================================================
module positional_deque import pdq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [CMD_W-1:0]           i_command,
    input  wire logic signed [VALUE_W-1:0]  i_value,
    input  wire logic [POS_W-1:0]           i_position,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [STAT_W-1:0]               o_status,
    output logic signed [VALUE_W-1:0]       o_removed_value,
    output logic [COUNT_W-1:0]              o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_job                job;
    t_res                res;
    logic [CW-1:0]       res_count;
    logic                core_busy;
    logic                res_valid;
    logic                res_take;
    logic                in_acc;

    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [VALUE_W-1:0]  r_out_removed;
    logic [COUNT_W-1:0]  r_out_count;

    assign job.cmd   = i_command;
    assign job.value = i_value;
    assign job.pos   = i_position;

    assign in_acc   = i_valid && !core_busy;
    // output register can take a result when empty or being drained
    assign res_take = !r_out_valid || !i_stall;

    pdq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_job       (job),
        .o_busy      (core_busy),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_res_count (res_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload loads only with a new result, so a stalled item holds
    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_status  <= res.status;
            r_out_removed <= res.removed;
            r_out_count   <= COUNT_W'(res_count);  // low bits only
        end
    end

    assign o_stall         = core_busy;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_count         = r_out_count;

    // an accepted command always occupies the sequencer next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("sequencer not busy after accept");

    // error results never carry a removed value
    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_removed_value == '0))
        else $error("removed value on error status");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res_count <= CW'(CAPACITY)))
        else $error("count above capacity");

    // a result moves into the output register only when it can be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_status) && $stable(o_count)))
        else $error("held result overwritten");

endmodule
`default_nettype wire

### src/pdq_ram.sv
`default_nettype none
// ============================================================================
// pdq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module pdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/pdq_core.sv
`default_nettype none
// ============================================================================
// pdq_core: command sequencer for the positional deque
// Circular buffer in RAM with head pointer; inserts and deletes stream the
// tail of the store one entry per cycle through read, then write back.
// ============================================================================
module pdq_core import pdq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire t_job                               i_job,
    output logic                                    o_busy,
    output logic                                    o_res_valid,
    input  wire logic                               i_res_take,
    output t_res                                    o_res,
    output logic [$clog2(CAPACITY+1)-1:0]           o_res_count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          r_state,   n_state;
    t_job                r_job,     n_job;
    logic [AW-1:0]       r_head,    n_head;
    logic [CW-1:0]       r_count,   n_count;
    logic [CW-1:0]       r_src,     n_src;
    logic [CW-1:0]       r_dst,     n_dst;
    logic [CW-1:0]       r_left,    n_left;
    logic [CW-1:0]       r_idx,     n_idx;
    logic                r_up,      n_up;
    logic                r_ins,     n_ins;
    logic                r_front,   n_front;
    logic                r_rvalid,  n_rvalid;
    logic                r_cap,     n_cap;
    logic [STAT_W-1:0]   r_status,  n_status;
    logic [VALUE_W-1:0]  r_removed, n_removed;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic [CMPW-1:0]     cnt_w;
    logic [CMPW-1:0]     pos_w;
    logic [CW-1:0]       pos_idx;
    logic                full;
    logic                empty;
    logic [AW-1:0]       head_dec;
    logic [AW-1:0]       head_inc;

    // logical index -> RAM address, modulo capacity
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(idx);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    pdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cnt_w    = CMPW'(r_count);
    assign pos_w    = CMPW'(r_job.pos);
    assign pos_idx  = CW'(pos_w - CMPW'(1));
    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_head    = r_head;
        n_count   = r_count;
        n_src     = r_src;
        n_dst     = r_dst;
        n_left    = r_left;
        n_idx     = r_idx;
        n_up      = r_up;
        n_ins     = r_ins;
        n_front   = r_front;
        n_rvalid  = 1'b0;
        n_cap     = 1'b0;
        n_status  = r_status;
        n_removed = r_removed;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, r_dst);
        ram_wdata = ram_rdata;
        ram_raddr = phys(r_head, r_src);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_job   = i_job;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status  = ST_OK;
                n_removed = '0;
                n_left    = '0;
                n_front   = 1'b0;
                n_ins     = 1'b0;
                n_up      = 1'b0;
                n_state   = S_DONE;
                case (r_job.cmd)
                    CMD_PUSH_FRONT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_ins   = 1'b1;
                            n_front = 1'b1;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_ins   = 1'b1;
                            n_idx   = r_count;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_INSERT: begin
                        if (r_job.pos == '0 || pos_w > cnt_w + CMPW'(1)) begin
                            n_status = ST_OOB;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            // open a gap: move entries idx..count-1 up one place
                            n_ins   = 1'b1;
                            n_idx   = pos_idx;
                            n_src   = r_count - CW'(1);
                            n_left  = r_count - pos_idx;
                            n_up    = 1'b1;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            ram_raddr = r_head;
                            n_rvalid  = 1'b1;
                            n_cap     = 1'b1;
                            n_front   = 1'b1;
                            n_state   = S_SHIFT;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            ram_raddr = phys(r_head, r_count - CW'(1));
                            n_rvalid  = 1'b1;
                            n_cap     = 1'b1;
                            n_state   = S_SHIFT;
                        end
                    end
                    CMD_DELETE: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (r_job.pos == '0 || pos_w > cnt_w) begin
                            n_status = ST_OOB;
                        end else begin
                            // take entry idx, then close the gap from behind
                            ram_raddr = phys(r_head, pos_idx);
                            n_rvalid  = 1'b1;
                            n_cap     = 1'b1;
                            n_src     = pos_idx + CW'(1);
                            n_left    = r_count - pos_idx - CW'(1);
                            n_state   = S_SHIFT;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end

            S_SHIFT: begin
                // write back the entry read last cycle (or capture it)
                if (r_rvalid) begin
                    if (r_cap) begin
                        n_removed = ram_rdata;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
                if (r_left != '0) begin
                    n_rvalid = 1'b1;
                    n_dst    = r_up ? r_src + CW'(1) : r_src - CW'(1);
                    n_src    = r_up ? r_src - CW'(1) : r_src + CW'(1);
                    n_left   = r_left - CW'(1);
                end else if (!r_rvalid) begin
                    if (r_ins) begin
                        ram_we    = 1'b1;
                        ram_wdata = r_job.value;
                        if (r_front) begin
                            ram_waddr = head_dec;
                            n_head    = head_dec;
                        end else begin
                            ram_waddr = phys(r_head, r_idx);
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        if (r_front) begin
                            n_head = head_inc;
                        end
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_rvalid <= 1'b0;
            r_cap    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_rvalid <= n_rvalid;
            r_cap    <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_left    <= n_left;
        r_idx     <= n_idx;
        r_up      <= n_up;
        r_ins     <= n_ins;
        r_front   <= n_front;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_res_valid    = (r_state == S_DONE);
    assign o_res.status   = r_status;
    assign o_res.removed  = r_removed;
    assign o_res_count    = r_count;

endmodule
`default_nettype wire
